[hdl/pia_pkg.sv]
// Package for the page id allocator: word widths, operation and status codes,
// register map and reset values. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

   // Fixed word field widths
   localparam int OP_BITS     = 2;
   localparam int PAGE_BITS   = 32;
   localparam int STATUS_BITS = 3;

   // Defaults for the top level parameters
   localparam int FREE_DEPTH_DEFAULT = 1024;
   localparam int ID_BITS_DEFAULT    = 32;

   // Register port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_DATA_BITS-1:0] CAPACITY_RESET   = 32'd65536;
   localparam logic [CSR_DATA_BITS-1:0] FIRST_FREE_RESET = 32'd1;

   typedef enum logic [OP_BITS-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_WRITE   = 2'd2
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_REUSED   = 3'd0,
      ST_NEW      = 3'd1,
      ST_FULL     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_INVALID  = 3'd4,
      ST_OVERFLOW = 3'd5,
      ST_WRITTEN  = 3'd6
   } status_type;

   // Register index is address bit 2
   typedef enum logic {
      REG_CAPACITY   = 1'b0,
      REG_FIRST_FREE = 1'b1
   } csr_reg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming word
      logic execute;   // apply the request and load the result register
   } pia_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_stall; // result register full and not taken this cycle
   } pia_stat_type;

endpackage

`default_nettype wire

[hdl/pia_if.sv]
// Handshake interfaces for request and result words.
// Depends on pia_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pia_req_if import pia_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_BITS-1:0]   operation;
   logic [PAGE_BITS-1:0] page;

   modport source (output valid, output operation, output page, input ready);
   modport sink   (input valid, input operation, input page, output ready);
endinterface

interface pia_rsp_if import pia_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PAGE_BITS-1:0]   page_out;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output page_out, output status, input ready);
   modport sink   (input valid, input page_out, input status, output ready);
endinterface

`default_nettype wire

[hdl/page_id_allocator.sv]
// Page id allocator: one result word per request word.
// The accepted word goes to the request registers; the execute step, stalled while the
// last result is held, then loads the result register using the free list memory's
// registered read. One request at a time; a new one is taken while the last result waits.
// Reset: synchronous; pointers and count cleared, registers to reset values,
// page counter to the first free id; the free list memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module page_id_allocator import pia_pkg::*; #(
   parameter int FREE_DEPTH = FREE_DEPTH_DEFAULT,
   parameter int ID_BITS    = ID_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pia_req_if.sink                       req_chan,
   pia_rsp_if.source                     rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   pia_cmd_type              cmd;
   pia_stat_type             stat;
   logic [CSR_DATA_BITS-1:0] capacity;
   logic [CSR_DATA_BITS-1:0] first_free;
   logic                     load_counter;
   logic                     ready;

   assign req_chan.ready = ready;

   pia_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .capacity     (capacity),
      .first_free   (first_free),
      .load_counter (load_counter)
   );

   pia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pia_datapath #(
      .FREE_DEPTH (FREE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_chan.operation),
      .req_page      (req_chan.page),
      .capacity      (capacity),
      .first_free    (first_free),
      .load_counter  (load_counter),
      .rsp           (rsp_chan)
   );

endmodule

`default_nettype wire

[hdl/pia_csr.sv]
// Configuration registers (capacity, first free id) on an APB-style port.
// Depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pia_csr import pia_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output logic      [CSR_DATA_BITS-1:0] capacity,
   output logic      [CSR_DATA_BITS-1:0] first_free,
   output logic                          load_counter
);

   logic [CSR_DATA_BITS-1:0] capacity_ff;
   logic [CSR_DATA_BITS-1:0] first_free_ff;
   logic                     wr_en;
   csr_reg_type              sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign sel    = csr_reg_type'(paddr[2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         first_free_ff <= FIRST_FREE_RESET;
      end else if (wr_en) begin
         unique case (sel)
            REG_CAPACITY:   capacity_ff   <= pwdata;
            REG_FIRST_FREE: first_free_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (sel)
         REG_CAPACITY:   prdata = capacity_ff;
         REG_FIRST_FREE: prdata = first_free_ff;
         default:        prdata = '0;
      endcase
   end

   // Writing the first free id reloads the page counter
   assign load_counter = wr_en & (sel == REG_FIRST_FREE);
   assign capacity     = capacity_ff;
   assign first_free   = pwdata;

endmodule

`default_nettype wire

[hdl/pia_ctrl.sv]
// Controller: accepts one request word, then runs one execute step that
// loads the result register. Depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pia_ctrl import pia_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire pia_stat_type stat,
   output pia_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait here while the previous result is still held
            if (!stat.out_stall) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/pia_datapath.sv]
// Datapath: free-id FIFO memory with head/tail/count, next-page counter,
// request holding registers and the result register. Depends on pia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pia_datapath import pia_pkg::*; #(
   parameter int FREE_DEPTH = FREE_DEPTH_DEFAULT,
   parameter int ID_BITS    = ID_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pia_cmd_type              cmd,
   output pia_stat_type                  stat,
   input  wire logic [OP_BITS-1:0]       req_operation,
   input  wire logic [PAGE_BITS-1:0]     req_page,
   input  wire logic [CSR_DATA_BITS-1:0] capacity,
   input  wire logic [CSR_DATA_BITS-1:0] first_free,
   input  wire logic                     load_counter,
   pia_rsp_if.source                     rsp
);

   localparam int PTR_W = $clog2(FREE_DEPTH);
   localparam int CNT_W = $clog2(FREE_DEPTH + 1);

   localparam logic [ID_BITS-1:0] INVALID_ID = '1;
   localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(FREE_DEPTH - 1);
   localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(FREE_DEPTH);

   logic [ID_BITS-1:0] free_mem [FREE_DEPTH];
   logic [ID_BITS-1:0] rd_ff;

   logic [OP_BITS-1:0] op_ff;
   logic [ID_BITS-1:0] pg_ff;

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_BITS-1:0] counter_ff, counter_in;

   logic                   rsp_valid_ff;
   logic [PAGE_BITS-1:0]   rsp_page_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   logic [ID_BITS-1:0] res_page;
   status_type         res_status;
   logic               push;
   logic [ID_BITS-1:0] want;

   assign stat.out_stall = rsp_valid_ff & ~rsp.ready;

   // Free list memory: registered read at the head, write at the tail
   always_ff @(posedge clock) begin
      rd_ff <= free_mem[head_ff];
      if (cmd.execute && push) begin
         free_mem[tail_ff] <= pg_ff;
      end
   end

   // Hold the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         pg_ff <= req_page[ID_BITS-1:0];
      end
   end

   // Request decode and next state
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      counter_in = counter_ff;
      res_page   = INVALID_ID;
      res_status = ST_INVALID;
      push       = 1'b0;
      want       = pg_ff + 1'b1;
      case (op_ff)
         OP_ALLOC: begin
            if (count_ff != '0) begin
               res_page   = rd_ff;
               head_in    = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               count_in   = count_ff - 1'b1;
               res_status = ST_REUSED;
            end else if ((CSR_DATA_BITS'(counter_ff) >= capacity) ||
                         (counter_ff == INVALID_ID)) begin
               res_status = ST_FULL;
            end else begin
               res_page   = counter_ff;
               counter_in = counter_ff + 1'b1;
               res_status = ST_NEW;
            end
         end
         OP_RELEASE: begin
            if (pg_ff == INVALID_ID) begin
               res_status = ST_INVALID;
            end else if (count_ff == FULL_COUNT) begin
               res_status = ST_OVERFLOW;
            end else begin
               push       = 1'b1;
               tail_in    = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
               count_in   = count_ff + 1'b1;
               res_status = ST_RELEASED;
            end
         end
         OP_WRITE: begin
            // pg below the invalid id, so want saturates at it
            if (pg_ff == INVALID_ID) begin
               res_status = ST_INVALID;
            end else begin
               if (want > counter_ff) begin
                  counter_in = want;
               end
               res_status = ST_WRITTEN;
            end
         end
         default: ;
      endcase
   end

   // Pointers and page counter
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         counter_ff <= FIRST_FREE_RESET[ID_BITS-1:0];
      end else if (load_counter) begin
         counter_ff <= first_free[ID_BITS-1:0];
      end else if (cmd.execute) begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         counter_ff <= counter_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_page_ff   <= PAGE_BITS'(res_page);
         rsp_status_ff <= res_status;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.page_out = rsp_page_ff;
   assign rsp.status   = rsp_status_ff;

endmodule

`default_nettype wire

[hdl/pia_checker.sv]
// Port-level checks for the page id allocator and the bind that attaches them.
// Depends on pia_pkg and page_id_allocator.
`timescale 1ns / 1ps
`default_nettype none

module pia_checker import pia_pkg::*; #(
   parameter int ID_BITS = ID_BITS_DEFAULT
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [PAGE_BITS-1:0]   page_out,
   input wire logic [STATUS_BITS-1:0] status
);

   localparam logic [PAGE_BITS-1:0] INVALID_PAGE =
      PAGE_BITS'((64'd1 << ID_BITS) - 64'd1);

   logic req_acc;
   assign req_acc = req_valid & req_ready;

   // held result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(page_out) && $stable(status))
      else $error("result word dropped or changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while another is in progress");

   // with the result register free at the accept, the execute step follows and the result shows
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && (!rsp_valid || rsp_ready) |-> ##2 rsp_valid)
      else $error("result word late");

   // only reuse and new carry an id; everything else reports the invalid id
   a_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_REUSED) && (status != ST_NEW)
         |-> page_out == INVALID_PAGE)
      else $error("id given with a non-allocating status");

endmodule

bind page_id_allocator pia_checker #(.ID_BITS(ID_BITS)) u_pia_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .page_out  (rsp_chan.page_out),
   .status    (rsp_chan.status)
);

`default_nettype wire

[bench/pia_result_check.sv]
// Result checker for the page id allocator: watches the request, result and
// register ports, keeps its own copy of the allocator state and compares.
// Depends on pia_pkg and the handshake interfaces in pia_if.
`timescale 1ns / 1ps

module pia_result_check import pia_pkg::*; #(
   parameter int FREE_DEPTH = FREE_DEPTH_DEFAULT,
   parameter int ID_BITS    = ID_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   pia_req_if                       req_mon,
   pia_rsp_if                       rsp_mon,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready,
   output int                       errors,
   output int                       grants_waiting
);

   localparam logic [PAGE_BITS-1:0] ID_MASK = PAGE_BITS'((64'd1 << ID_BITS) - 64'd1);

   typedef struct packed {
      logic [PAGE_BITS-1:0] page_out;
      status_type           status;
   } grant_word_type;

   // Shadow copy of the allocator state and registers
   logic [CSR_DATA_BITS-1:0] capacity_reg;
   logic [CSR_DATA_BITS-1:0] first_free_reg;
   logic [PAGE_BITS-1:0]     next_page;
   logic [PAGE_BITS-1:0]     freed_ids[$];
   grant_word_type           grants_due[$];

   initial begin
      errors         = 0;
      grants_waiting = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      errors++;
   endtask

   // Apply one request word to the shadow state, return the result word due
   function automatic grant_word_type predict_grant(input logic [OP_BITS-1:0] op,
                                                    input logic [PAGE_BITS-1:0] page_in);
      logic [PAGE_BITS-1:0] pg;
      grant_word_type       g;
      pg         = page_in & ID_MASK;
      g.page_out = ID_MASK;
      g.status   = ST_INVALID;
      case (op)
         OP_ALLOC: begin
            // reuse first, no capacity check on a reused id
            if (freed_ids.size() > 0) begin
               g.page_out = freed_ids[0];
               freed_ids.delete(0);
               g.status   = ST_REUSED;
            end else if (next_page >= capacity_reg || next_page >= ID_MASK) begin
               g.status = ST_FULL;
            end else begin
               g.page_out = next_page;
               next_page  = next_page + 1'b1;
               g.status   = ST_NEW;
            end
         end
         OP_RELEASE: begin
            if (pg == ID_MASK) begin
               g.status = ST_INVALID;
            end else if (freed_ids.size() >= FREE_DEPTH) begin
               g.status = ST_OVERFLOW;
            end else begin
               freed_ids.push_back(pg);
               g.status = ST_RELEASED;
            end
         end
         OP_WRITE: begin
            // pg is below the invalid id, so pg + 1 cannot wrap
            if (pg == ID_MASK) begin
               g.status = ST_INVALID;
            end else begin
               if (pg + 1'b1 > next_page) next_page = pg + 1'b1;
               g.status = ST_WRITTEN;
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   always @(posedge clock) begin
      logic [CSR_DATA_BITS-1:0] reg_want;
      grant_word_type           due;
      if (reset) begin
         capacity_reg   = CAPACITY_RESET;
         first_free_reg = FIRST_FREE_RESET;
         next_page      = FIRST_FREE_RESET & ID_MASK;
         freed_ids.delete();
         grants_due.delete();
      end else begin
         // register port: writes update the shadow, reads are compared
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (csr_reg_type'(paddr[2]))
                  REG_CAPACITY: capacity_reg = pwdata;
                  REG_FIRST_FREE: begin
                     first_free_reg = pwdata;
                     next_page      = pwdata & ID_MASK;
                  end
                  default: ;
               endcase
            end else begin
               reg_want = (csr_reg_type'(paddr[2]) == REG_FIRST_FREE) ? first_free_reg
                                                                       : capacity_reg;
               if (prdata !== reg_want) report_mismatch("register read", prdata, reg_want);
            end
         end

         // result words against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (grants_due.size() == 0) begin
               report_mismatch("result word with none due", rsp_mon.page_out,
                               {29'd0, rsp_mon.status});
            end else begin
               due = grants_due[0];
               grants_due.delete(0);
               if (rsp_mon.page_out !== due.page_out)
                  report_mismatch("page_out", rsp_mon.page_out, due.page_out);
               if (rsp_mon.status !== due.status)
                  report_mismatch("status", {29'd0, rsp_mon.status}, {29'd0, due.status});
            end
         end

         // accepted request words
         if (req_mon.valid && req_mon.ready)
            grants_due.push_back(predict_grant(req_mon.operation, req_mon.page));
      end
      grants_waiting = grants_due.size();
   end

endmodule

[bench/page_id_allocator_tb.sv]
// Testbench top for the page id allocator: clock, reset, request stimulus,
// register writes and result back-pressure; checking is done by pia_result_check.
// Depends on pia_pkg, pia_if, the allocator RTL and pia_result_check.
`timescale 1ns / 1ps

module page_id_allocator_tb import pia_pkg::*;;

   localparam int DEPTH = FREE_DEPTH_DEFAULT;
   localparam int IDW   = ID_BITS_DEFAULT;

   localparam logic [OP_BITS-1:0]       OP_UNUSED       = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_CAPACITY   = {REG_CAPACITY, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FIRST_FREE = {REG_FIRST_FREE, 2'b00};
   localparam int PHASES      = 16;
   localparam int PHASE_WORDS = 60;
   localparam int FLOOD_WORDS = DEPTH + 16;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata, prdata;
   int   check_errors, results_due;

   // sender and receiver pacing
   int   burst_left = 0;
   logic steady     = 1'b0;
   logic long_hold  = 1'b0;

   pia_req_if req_chan ();
   pia_rsp_if rsp_chan ();

   page_id_allocator #(.FREE_DEPTH(DEPTH), .ID_BITS(IDW)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pia_result_check #(.FREE_DEPTH(DEPTH), .ID_BITS(IDW)) result_check (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .errors(check_errors), .grants_waiting(results_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one request word; entered and left at a falling edge
   task automatic send_word(input logic [OP_BITS-1:0] op, input logic [PAGE_BITS-1:0] pg);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.page      <= pg;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Stop sending and wait until every result word has come back
   task automatic drain;
      req_chan.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register access: setup cycle, access cycle, then a quiet cycle
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_capacity;
      case ($urandom_range(0, 5))
         0:       return 32'd1;
         1:       return 32'hFFFF_FFFE;
         2, 3:    return $urandom_range(1, 48);
         4:       return $urandom_range(1, 2000);
         default: return $urandom_range(1, 32'hFFFF_FFFE);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_first_free;
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFE;
         2, 3:    return $urandom_range(0, 40);
         4:       return $urandom_range(0, 2000);
         default: return $urandom_range(0, 32'hFFFF_FFFE);
      endcase
   endfunction

   // Mostly small ids so that releases and write notices interact
   function automatic logic [PAGE_BITS-1:0] pick_page;
      case ($urandom_range(0, 9))
         0:             return '0;
         1:             return '1;
         2:             return 32'hFFFF_FFFE;
         3, 4, 5, 6:    return $urandom_range(0, 63);
         7:             return $urandom_range(0, 4000);
         default:       return $urandom();
      endcase
   endfunction

   // mix 0 balanced, 1 allocate heavy, 2 release heavy
   function automatic logic [OP_BITS-1:0] pick_op(input int mix);
      int r;
      int alloc_top;
      int rel_top;
      r         = $urandom_range(0, 99);
      alloc_top = (mix == 1) ? 80 : (mix == 2) ? 30 : 50;
      rel_top   = (mix == 1) ? 96 : (mix == 2) ? 92 : 88;
      if (r < 2)         return OP_UNUSED;
      if (r < alloc_top) return OP_ALLOC;
      if (r < rel_top)   return OP_RELEASE;
      return OP_WRITE;
   endfunction

   // Result receiver: changing stall patterns, plus a long hold on request
   initial begin
      int   mode_left;
      int   rx_mode;
      int   hold_left;
      int   tick;
      logic rdy;
      mode_left = 0;
      rx_mode   = 0;
      hold_left = 0;
      tick      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 120);
         end
         mode_left--;
         if (long_hold) begin
            hold_left = HOLD_CYCLES;
            long_hold = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            case (rx_mode)
               0:       rdy = 1'b1;
               1:       rdy = $urandom_range(0, 1);
               2:       rdy = ($urandom_range(0, 3) == 0);
               default: rdy = (tick % 5 != 0);
            endcase
         end
         tick++;
         rsp_chan.ready <= rdy;
      end
   end

   // Stimulus
   initial begin
      int mix;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_ALLOC;
      req_chan.page      <= '0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values read back
      csr_access(1'b0, ADDR_CAPACITY, '0);
      csr_access(1'b0, ADDR_FIRST_FREE, '0);

      // directed: new ids, reuse in release order, invalid ids, unused code
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '1);
      send_word(OP_RELEASE, 32'd5);
      send_word(OP_RELEASE, '0);
      send_word(OP_RELEASE, '1);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
      send_word(OP_WRITE, 32'd100);
      send_word(OP_WRITE, 32'd7);
      send_word(OP_ALLOC, '0);
      send_word(OP_WRITE, '1);
      send_word(OP_UNUSED, '0);
      send_word(OP_UNUSED, '1);
      // counter saturates at the invalid id; reuse still works past capacity
      send_word(OP_WRITE, 32'hFFFF_FFFE);
      send_word(OP_ALLOC, '0);
      send_word(OP_RELEASE, 32'hFFFF_FFFE);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);

      // smallest capacity, counter from zero
      drain;
      csr_access(1'b1, ADDR_CAPACITY, 32'd1);
      csr_access(1'b1, ADDR_FIRST_FREE, 32'd0);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);

      // largest capacity with the counter just below it
      drain;
      csr_access(1'b1, ADDR_CAPACITY, 32'hFFFF_FFFE);
      csr_access(1'b1, ADDR_FIRST_FREE, 32'hFFFF_FFFD);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
      drain;
      csr_access(1'b1, ADDR_FIRST_FREE, 32'hFFFF_FFFE);
      csr_access(1'b0, ADDR_FIRST_FREE, '0);
      send_word(OP_ALLOC, '0);

      // random phases, each with its own settings, mix and pacing
      for (int ph = 0; ph < PHASES; ph++) begin
         drain;
         if ($urandom_range(0, 3) != 0) csr_access(1'b1, ADDR_CAPACITY, pick_capacity());
         if ($urandom_range(0, 3) != 0) csr_access(1'b1, ADDR_FIRST_FREE, pick_first_free());
         csr_access(1'b0, ($urandom_range(0, 1) != 0) ? ADDR_CAPACITY : ADDR_FIRST_FREE, '0);
         mix    = $urandom_range(0, 2);
         steady = ($urandom_range(0, 3) == 0);
         if (ph == 4 || ph == 11) begin
            // receiver holds off while the sender keeps offering
            steady    = 1'b1;
            long_hold = 1'b1;
         end
         if (ph == 7) begin
            // fill the free list and push past it, then reuse a few
            for (int n = 0; n < FLOOD_WORDS; n++)
               send_word(OP_RELEASE, $urandom_range(0, 32'hFFFF_FFFE));
            send_word(OP_RELEASE, '1);
            send_word(OP_RELEASE, '0);
            mix = 1;
         end
         for (int n = 0; n < PHASE_WORDS; n++)
            send_word(pick_op(mix), pick_page());
      end

      drain;
      repeat (8) @(negedge clock);
      if (check_errors == 0 && results_due == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
